// File: rtl/sgr_pkg.sv
// shared types, constants and font/mark tables for the scaled glyph rasterizer
`default_nettype none

package sgr_pkg;

    localparam int COORD_BITS_DEF = 10;
    localparam int MAX_RESULTS    = 26;
    localparam int CNT_W          = $clog2(MAX_RESULTS);

    // work slots of one glyph, emitted lowest first
    localparam int SLOTS      = 51;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int SLOT_PRINT = 40;
    localparam int SLOT_LINE  = 41;
    localparam int SLOT_SHAPE = 42;
    localparam int SLOT_TONE  = 46;
    localparam int SLOT_DOT   = 50;

    typedef enum logic [1:0] {
        CMD_RECT  = 2'd0,
        CMD_LINE  = 2'd1,
        CMD_PRINT = 2'd2
    } t_cmd;

    typedef struct packed {
        logic [15:0]      color;
        logic [2:0]       tone;
        logic [1:0]       shape;
        logic [7:0]       ch;
        logic [SLOTS-1:0] mask;
    } t_job;

    function automatic logic [40:0] pack_cols(input logic [7:0] c0, input logic [7:0] c1,
                                              input logic [7:0] c2, input logic [7:0] c3,
                                              input logic [7:0] c4);
        pack_cols = {1'b1, c4, c3, c2, c1, c0};
    endfunction

    // bit 40 set when the code is in the font, column c at bits c*8 +: 8
    function automatic logic [40:0] font_lookup(input logic [7:0] ch);
        logic [40:0] f;
        f = '0;
        case (ch)
            8'h20: f = pack_cols(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
            8'h2D: f = pack_cols(8'h08, 8'h08, 8'h08, 8'h08, 8'h08);
            8'h2E: f = pack_cols(8'h00, 8'h00, 8'h60, 8'h60, 8'h00);
            8'h2F: f = pack_cols(8'h20, 8'h10, 8'h08, 8'h04, 8'h02);
            8'h3A: f = pack_cols(8'h00, 8'h00, 8'h14, 8'h00, 8'h00);
            8'h30: f = pack_cols(8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E);
            8'h31: f = pack_cols(8'h00, 8'h42, 8'h7F, 8'h40, 8'h00);
            8'h32: f = pack_cols(8'h72, 8'h49, 8'h49, 8'h49, 8'h46);
            8'h33: f = pack_cols(8'h21, 8'h41, 8'h49, 8'h4D, 8'h33);
            8'h34: f = pack_cols(8'h18, 8'h14, 8'h12, 8'h7F, 8'h10);
            8'h35: f = pack_cols(8'h27, 8'h45, 8'h45, 8'h45, 8'h39);
            8'h36: f = pack_cols(8'h3C, 8'h4A, 8'h49, 8'h49, 8'h31);
            8'h37: f = pack_cols(8'h41, 8'h21, 8'h11, 8'h09, 8'h07);
            8'h38: f = pack_cols(8'h36, 8'h49, 8'h49, 8'h49, 8'h36);
            8'h39: f = pack_cols(8'h46, 8'h49, 8'h49, 8'h29, 8'h1E);
            8'h41: f = pack_cols(8'h7C, 8'h12, 8'h11, 8'h12, 8'h7C);
            8'h42: f = pack_cols(8'h7F, 8'h49, 8'h49, 8'h49, 8'h36);
            8'h43: f = pack_cols(8'h3E, 8'h41, 8'h41, 8'h41, 8'h22);
            8'h44: f = pack_cols(8'h7F, 8'h41, 8'h41, 8'h41, 8'h3E);
            8'h45: f = pack_cols(8'h7F, 8'h49, 8'h49, 8'h49, 8'h41);
            8'h46: f = pack_cols(8'h7F, 8'h09, 8'h09, 8'h09, 8'h01);
            8'h47: f = pack_cols(8'h3E, 8'h41, 8'h41, 8'h51, 8'h73);
            8'h48: f = pack_cols(8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F);
            8'h49: f = pack_cols(8'h00, 8'h41, 8'h7F, 8'h41, 8'h00);
            8'h4A: f = pack_cols(8'h20, 8'h40, 8'h41, 8'h3F, 8'h01);
            8'h4B: f = pack_cols(8'h7F, 8'h08, 8'h14, 8'h22, 8'h41);
            8'h4C: f = pack_cols(8'h7F, 8'h40, 8'h40, 8'h40, 8'h40);
            8'h4D: f = pack_cols(8'h7F, 8'h02, 8'h1C, 8'h02, 8'h7F);
            8'h4E: f = pack_cols(8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F);
            8'h4F: f = pack_cols(8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E);
            8'h50: f = pack_cols(8'h7F, 8'h09, 8'h09, 8'h09, 8'h06);
            8'h51: f = pack_cols(8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E);
            8'h52: f = pack_cols(8'h7F, 8'h09, 8'h19, 8'h29, 8'h46);
            8'h53: f = pack_cols(8'h26, 8'h49, 8'h49, 8'h49, 8'h32);
            8'h54: f = pack_cols(8'h03, 8'h01, 8'h7F, 8'h01, 8'h03);
            8'h55: f = pack_cols(8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F);
            8'h56: f = pack_cols(8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F);
            8'h57: f = pack_cols(8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F);
            8'h58: f = pack_cols(8'h63, 8'h14, 8'h08, 8'h14, 8'h63);
            8'h59: f = pack_cols(8'h03, 8'h04, 8'h78, 8'h04, 8'h03);
            8'h5A: f = pack_cols(8'h61, 8'h59, 8'h49, 8'h4D, 8'h43);
            default: f = '0;
        endcase
        font_lookup = f;
    endfunction

    // shape mark pixel k as {col, row}
    function automatic logic [5:0] shape_px(input logic [1:0] shape, input logic [1:0] k);
        logic [5:0] p;
        case ({shape, k})
            4'b0100: p = {3'd1, 3'd2};
            4'b0101: p = {3'd2, 3'd1};
            4'b0110: p = {3'd3, 3'd1};
            4'b0111: p = {3'd4, 3'd2};
            4'b1000: p = {3'd1, 3'd0};
            4'b1001: p = {3'd2, 3'd1};
            4'b1010: p = {3'd3, 3'd1};
            4'b1011: p = {3'd4, 3'd0};
            4'b1100: p = {3'd4, 3'd1};
            4'b1101: p = {3'd5, 3'd0};
            default: p = '0;
        endcase
        shape_px = p;
    endfunction

    // tone mark pixel k as {col, row}
    function automatic logic [5:0] tone_px(input logic [2:0] tone, input logic [1:0] k);
        logic [5:0] p;
        case ({tone, k})
            5'b00100: p = {3'd4, 3'd1};
            5'b00101: p = {3'd3, 3'd2};
            5'b01000: p = {3'd2, 3'd0};
            5'b01001: p = {3'd3, 3'd1};
            5'b01100: p = {3'd2, 3'd0};
            5'b01101: p = {3'd3, 3'd0};
            5'b01110: p = {3'd3, 3'd1};
            5'b01111: p = {3'd2, 3'd2};
            5'b10000: p = {3'd1, 3'd1};
            5'b10001: p = {3'd2, 3'd0};
            5'b10010: p = {3'd3, 3'd1};
            5'b10011: p = {3'd4, 3'd0};
            default:  p = '0;
        endcase
        tone_px = p;
    endfunction

    // floor(3*s/2)
    function automatic logic [3:0] sc15(input logic [2:0] s);
        logic [3:0] v;
        case (s)
            3'd0: v = 4'd0;
            3'd1: v = 4'd1;
            3'd2: v = 4'd3;
            3'd3: v = 4'd4;
            3'd4: v = 4'd6;
            3'd5: v = 4'd7;
            3'd6: v = 4'd9;
            3'd7: v = 4'd10;
            default: v = 4'd0;
        endcase
        sc15 = v;
    endfunction

endpackage

`default_nettype wire

// File: rtl/sgr_front.sv
// front end: font lookup and work-slot mask for one glyph
`default_nettype none

module sgr_front
    import sgr_pkg::*;
(
    input  wire logic [7:0] i_base_char,
    input  wire logic [2:0] i_top_mark,
    input  wire logic [1:0] i_shape_mark,
    input  wire logic       i_dot_below,
    input  wire logic       i_stroke_bar,
    input  wire logic [15:0] i_pen_color,
    output t_job            o_job,
    output logic            o_has_work
);

    logic [40:0] font;
    logic [3:0]  shape_slots;
    logic [3:0]  tone_slots;

    always_comb begin
        font = font_lookup(i_base_char);
        case (i_shape_mark)
            2'd1, 2'd2: shape_slots = 4'b1111;
            2'd3:       shape_slots = 4'b0011;
            default:    shape_slots = 4'b0000;
        endcase
        case (i_top_mark)
            3'd1, 3'd2: tone_slots = 4'b0011;
            3'd3, 3'd4: tone_slots = 4'b1111;
            default:    tone_slots = 4'b0000;
        endcase
        o_job.mask  = {i_dot_below, tone_slots, shape_slots, i_stroke_bar, ~font[40],
                       font[39:0]};
        o_job.ch    = i_base_char;
        o_job.shape = i_shape_mark;
        o_job.tone  = i_top_mark;
        o_job.color = i_pen_color;
        o_has_work  = |o_job.mask;
    end

endmodule

`default_nettype wire

// File: rtl/sgr_queue.sv
// two-entry job queue between front end and command sequencer
`default_nettype none

module sgr_queue #(
    parameter int W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_wr_valid,
    output logic              o_wr_ready,
    input  wire logic [W-1:0] i_wr_data,
    output logic              o_rd_valid,
    input  wire logic         i_rd_ready,
    output logic [W-1:0]      o_rd_data
);

    logic [W-1:0] r_data [2];
    logic         r_wptr;
    logic         r_rptr;
    logic [1:0]   r_cnt;
    logic         wr_en;
    logic         rd_en;

    assign o_wr_ready = (r_cnt != 2'd2);
    assign o_rd_valid = (r_cnt != 2'd0);
    assign o_rd_data  = r_data[r_rptr];
    assign wr_en      = i_wr_valid && o_wr_ready;
    assign rd_en      = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_data[r_wptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (wr_en) begin
                r_wptr <= ~r_wptr;
            end
            if (rd_en) begin
                r_rptr <= ~r_rptr;
            end
            case ({wr_en, rd_en})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/sgr_back.sv
// command sequencer: one command per cycle from the slot mask while the output is not stalled, with output register
`default_nettype none

module sgr_back
    import sgr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_job_valid,
    output logic                       o_job_ready,
    input  t_job                       i_job,
    input  wire logic [COORD_BITS-1:0] i_x,
    input  wire logic [COORD_BITS-1:0] i_y,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output t_cmd                       o_cmd,
    output logic [COORD_BITS:0]        o_first_x,
    output logic [COORD_BITS:0]        o_first_y,
    output logic [COORD_BITS:0]        o_second_x,
    output logic [COORD_BITS:0]        o_second_y,
    output logic [15:0]                o_color,
    output logic                       o_last
);

    localparam int CW = COORD_BITS + 1;

    logic                  r_busy;
    logic [SLOTS-1:0]      r_mask;
    logic [CNT_W-1:0]      r_cnt;
    logic [7:0]            r_ch;
    logic [1:0]            r_shape;
    logic [2:0]            r_tone;
    logic [15:0]           r_color;
    logic [COORD_BITS-1:0] r_x;
    logic [COORD_BITS-1:0] r_y;

    logic                  r_out_valid;
    t_cmd                  r_cmd;
    logic [CW-1:0]         r_fx;
    logic [CW-1:0]         r_fy;
    logic [CW-1:0]         r_sx;
    logic [CW-1:0]         r_sy;
    logic [15:0]           r_ocolor;
    logic                  r_last;

    logic [SLOT_W-1:0]     sel;
    logic [SLOTS-1:0]      mask_rest;
    logic [2:0]            pc;
    logic [2:0]            pr;
    logic [1:0]            k;
    logic [CW-1:0]         xe;
    logic [CW-1:0]         ye;
    logic [CW-1:0]         yb;
    logic [16:0]           ch_w;
    t_cmd                  cmd;
    logic [CW-1:0]         fx;
    logic [CW-1:0]         fy;
    logic [CW-1:0]         sx;
    logic [CW-1:0]         sy;
    logic                  advance;
    logic                  emit;
    logic                  last_now;
    logic                  pop;

    always_comb begin
        sel = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                sel = SLOT_W'(i);
            end
        end
        mask_rest = r_mask & ~({{(SLOTS-1){1'b0}}, 1'b1} << sel);

        xe   = {1'b0, r_x};
        ye   = {1'b0, r_y};
        ch_w = {9'd0, r_ch};
        pc   = '0;
        pr   = '0;
        k    = '0;
        yb   = ye;
        cmd  = CMD_RECT;
        if (sel < SLOT_W'(SLOT_PRINT)) begin
            pc = sel[5:3];
            pr = sel[2:0];
        end else if (sel == SLOT_W'(SLOT_PRINT)) begin
            cmd = CMD_PRINT;
        end else if (sel == SLOT_W'(SLOT_LINE)) begin
            cmd = CMD_LINE;
        end else if (sel < SLOT_W'(SLOT_TONE)) begin
            k        = 2'(sel - SLOT_W'(SLOT_SHAPE));
            {pc, pr} = shape_px(r_shape, k);
            yb       = (ye >= CW'(3)) ? ye - CW'(3) : '0;
        end else if (sel < SLOT_W'(SLOT_DOT)) begin
            k        = 2'(sel - SLOT_W'(SLOT_TONE));
            {pc, pr} = tone_px(r_tone, k);
            yb       = (ye >= CW'(6)) ? ye - CW'(6) : '0;
        end else begin
            // dot below sits at source pixel column 3, row 0
            pc = 3'd3;
            yb = ye + CW'(12);
        end

        case (cmd)
            CMD_LINE: begin
                fx = xe + CW'(2);
                fy = ye + CW'(6);
                sx = xe + CW'(8);
                sy = ye + CW'(3);
            end
            CMD_PRINT: begin
                fx = xe;
                fy = ye + CW'(2);
                sx = ch_w[CW-1:0];
                sy = '0;
            end
            default: begin
                fx = xe + CW'(sc15(pc));
                fy = yb + CW'(sc15(pr));
                sx = pc[0] ? CW'(2) : CW'(1);
                sy = pr[0] ? CW'(2) : CW'(1);
            end
        endcase
    end

    assign advance     = !r_out_valid || i_ready;
    assign emit        = r_busy && advance;
    assign last_now    = (mask_rest == '0) || (r_cnt == CNT_W'(MAX_RESULTS - 1));
    assign pop         = advance && i_job_valid && (!r_busy || last_now);
    assign o_job_ready = advance && (!r_busy || last_now);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= emit;
            end
            if (pop) begin
                r_busy <= 1'b1;
            end else if (emit && last_now) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_mask  <= i_job.mask;
            r_cnt   <= '0;
            r_ch    <= i_job.ch;
            r_shape <= i_job.shape;
            r_tone  <= i_job.tone;
            r_color <= i_job.color;
            r_x     <= i_x;
            r_y     <= i_y;
        end else if (emit) begin
            r_mask <= mask_rest;
            r_cnt  <= r_cnt + CNT_W'(1);
        end
        if (emit) begin
            r_cmd    <= cmd;
            r_fx     <= fx;
            r_fy     <= fy;
            r_sx     <= sx;
            r_sy     <= sy;
            r_ocolor <= r_color;
            r_last   <= last_now;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_cmd      = r_cmd;
    assign o_first_x  = r_fx;
    assign o_first_y  = r_fy;
    assign o_second_x = r_sx;
    assign o_second_y = r_sy;
    assign o_color    = r_ocolor;
    assign o_last     = r_last;

    a_busy_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_mask != '0))
        else $error("sequencer busy with empty slot mask");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt < CNT_W'(MAX_RESULTS)))
        else $error("command count past limit");

    a_single_slot_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && advance && $onehot(r_mask)) |=> (r_out_valid && r_last))
        else $error("final slot not marked last");

    a_pop_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> (!r_busy || emit))
        else $error("job loaded over unfinished glyph");

endmodule

`default_nettype wire

// File: rtl/scaled_glyph_rasterizer_unit.sv
// top level: glyph stream in, drawing command stream out
// path: the first command of a glyph passes the job queue, the sequencer job registers and
// the command output register; throughput: one command per cycle while i_m_tready allows,
// a glyph yields n commands (at most 26) through the single command output register
// a glyph that yields no command is taken when the queue has room and leaves nothing behind
// reset (synchronous, active low) empties the job queue and the output register
`default_nettype none

module scaled_glyph_rasterizer_unit
    import sgr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int IN_W   = 31 + 2 * COORD_BITS,
    localparam int IN_TW  = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W  = 4 * (COORD_BITS + 1) + 16,
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    // base_char, top_mark, shape_mark, dot_below, stroke_bar, origin_x, origin_y, pen_color
    input  wire logic [IN_TW-1:0]  i_s_tdata,
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    // first_x, first_y, second_x, second_y, out_color
    output logic [OUT_TW-1:0]      o_m_tdata,
    // command
    output logic [1:0]             o_m_tuser,
    output logic                   o_m_tlast
);

    localparam int CB = COORD_BITS;
    localparam int QW = $bits(t_job) + 2 * CB;

    t_job           f_job;
    logic           f_has_work;
    logic [CB-1:0]  in_x;
    logic [CB-1:0]  in_y;
    logic [QW-1:0]  q_wdata;
    logic [QW-1:0]  q_rdata;
    logic           q_wr_ready;
    logic           q_rd_valid;
    logic           q_rd_ready;
    t_job           b_job;
    logic [CB-1:0]  b_x;
    logic [CB-1:0]  b_y;
    t_cmd           m_cmd;
    logic [CB:0]    m_fx;
    logic [CB:0]    m_fy;
    logic [CB:0]    m_sx;
    logic [CB:0]    m_sy;
    logic [15:0]    m_color;

    assign in_x = i_s_tdata[15 +: CB];
    assign in_y = i_s_tdata[15 + CB +: CB];

    sgr_front u_front (
        .i_base_char  (i_s_tdata[7:0]),
        .i_top_mark   (i_s_tdata[10:8]),
        .i_shape_mark (i_s_tdata[12:11]),
        .i_dot_below  (i_s_tdata[13]),
        .i_stroke_bar (i_s_tdata[14]),
        .i_pen_color  (i_s_tdata[15 + 2 * CB +: 16]),
        .o_job        (f_job),
        .o_has_work   (f_has_work)
    );

    // glyphs with nothing to draw are taken and dropped
    assign q_wdata    = {in_y, in_x, f_job};
    assign o_s_tready = q_wr_ready;

    sgr_queue #(
        .W (QW)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_s_tvalid && f_has_work),
        .o_wr_ready (q_wr_ready),
        .i_wr_data  (q_wdata),
        .o_rd_valid (q_rd_valid),
        .i_rd_ready (q_rd_ready),
        .o_rd_data  (q_rdata)
    );

    assign {b_y, b_x, b_job} = q_rdata;

    sgr_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_rd_valid),
        .o_job_ready (q_rd_ready),
        .i_job       (b_job),
        .i_x         (b_x),
        .i_y         (b_y),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_cmd       (m_cmd),
        .o_first_x   (m_fx),
        .o_first_y   (m_fy),
        .o_second_x  (m_sx),
        .o_second_y  (m_sy),
        .o_color     (m_color),
        .o_last      (o_m_tlast)
    );

    assign o_m_tdata = OUT_TW'({m_color, m_sy, m_sx, m_fy, m_fx});
    assign o_m_tuser = m_cmd;

endmodule

`default_nettype wire

// File: bench/tb.sv
// self-checking bench for the scaled glyph rasterizer: glyph items in, draw commands out
`default_nettype none

module tb;
    import sgr_pkg::*;

    localparam int CLK_HALF   = 5;
    localparam int IDLE_LIMIT = 3000;
    localparam int RAND_ITEMS = 460;
    localparam int LONG_HOLD  = 400;
    localparam int TAIL_WAIT  = 20;

    localparam bit [2:0] TONE_ACUTE = 3'd1;
    localparam bit [2:0] TONE_GRAVE = 3'd2;
    localparam bit [2:0] TONE_HOOK  = 3'd3;
    localparam bit [2:0] TONE_TILDE = 3'd4;
    localparam bit [1:0] SHAPE_CIRCUMFLEX = 2'd1;
    localparam bit [1:0] SHAPE_BREVE      = 2'd2;
    localparam bit [1:0] SHAPE_HORN       = 2'd3;

    localparam string FONT_CODES = " -./:0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";

    // packed so that base_char lands in the lowest bits, as on the wire
    typedef struct packed {
        bit [15:0] color;
        bit [9:0]  y;
        bit [9:0]  x;
        bit        stroke;
        bit        dot;
        bit [1:0]  shape;
        bit [2:0]  tone;
        bit [7:0]  ch;
    } t_glyph;

    typedef struct {
        t_glyph g;
        bit     drain_before;
    } t_glyph_entry;

    typedef struct {
        t_cmd      cmd;
        bit [10:0] fx;
        bit [10:0] fy;
        bit [10:0] sx;
        bit [10:0] sy;
        bit [15:0] color;
        bit        last;
    } t_draw_cmd;

    typedef struct packed {
        bit            known;
        bit [0:4][7:0] cols;
    } t_font_rec;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    // base_char, top_mark, shape_mark, dot_below, stroke_bar, origin_x, origin_y, pen_color
    logic [55:0] i_s_tdata = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    // first_x, first_y, second_x, second_y, out_color
    logic [63:0] o_m_tdata;
    // command
    logic [1:0]  o_m_tuser;
    logic        o_m_tlast;

    t_glyph_entry glyph_q[$];
    t_draw_cmd    draw_q[$];
    t_draw_cmd    glyph_cmds[$];

    int err_cnt = 0;
    int glyphs_sent = 0;
    int glyphs_total = 0;
    int cmds_seen = 0;
    int rect_cnt = 0, line_cnt = 0, print_cnt = 0;
    int capped_cnt = 0, empty_cnt = 0;
    int cmds_asked = 0;

    scaled_glyph_rasterizer_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always #CLK_HALF i_clk = ~i_clk;

    function automatic t_font_rec font_columns(input bit [7:0] ch);
        t_font_rec f;
        f.known = 1'b1;
        case (ch)
            " ": f.cols = 40'h00_00_00_00_00;
            "-": f.cols = 40'h08_08_08_08_08;
            ".": f.cols = 40'h00_00_60_60_00;
            "/": f.cols = 40'h20_10_08_04_02;
            ":": f.cols = 40'h00_00_14_00_00;
            "0": f.cols = 40'h3E_51_49_45_3E;
            "1": f.cols = 40'h00_42_7F_40_00;
            "2": f.cols = 40'h72_49_49_49_46;
            "3": f.cols = 40'h21_41_49_4D_33;
            "4": f.cols = 40'h18_14_12_7F_10;
            "5": f.cols = 40'h27_45_45_45_39;
            "6": f.cols = 40'h3C_4A_49_49_31;
            "7": f.cols = 40'h41_21_11_09_07;
            "8": f.cols = 40'h36_49_49_49_36;
            "9": f.cols = 40'h46_49_49_29_1E;
            "A": f.cols = 40'h7C_12_11_12_7C;
            "B": f.cols = 40'h7F_49_49_49_36;
            "C": f.cols = 40'h3E_41_41_41_22;
            "D": f.cols = 40'h7F_41_41_41_3E;
            "E": f.cols = 40'h7F_49_49_49_41;
            "F": f.cols = 40'h7F_09_09_09_01;
            "G": f.cols = 40'h3E_41_41_51_73;
            "H": f.cols = 40'h7F_08_08_08_7F;
            "I": f.cols = 40'h00_41_7F_41_00;
            "J": f.cols = 40'h20_40_41_3F_01;
            "K": f.cols = 40'h7F_08_14_22_41;
            "L": f.cols = 40'h7F_40_40_40_40;
            "M": f.cols = 40'h7F_02_1C_02_7F;
            "N": f.cols = 40'h7F_04_08_10_7F;
            "O": f.cols = 40'h3E_41_41_41_3E;
            "P": f.cols = 40'h7F_09_09_09_06;
            "Q": f.cols = 40'h3E_41_51_21_5E;
            "R": f.cols = 40'h7F_09_19_29_46;
            "S": f.cols = 40'h26_49_49_49_32;
            "T": f.cols = 40'h03_01_7F_01_03;
            "U": f.cols = 40'h3F_40_40_40_3F;
            "V": f.cols = 40'h1F_20_40_20_1F;
            "W": f.cols = 40'h3F_40_38_40_3F;
            "X": f.cols = 40'h63_14_08_14_63;
            "Y": f.cols = 40'h03_04_78_04_03;
            "Z": f.cols = 40'h61_59_49_4D_43;
            default: begin
                f.known = 1'b0;
                f.cols  = '0;
            end
        endcase
        return f;
    endfunction

    // floor(3*s/2)
    function automatic int scaled(input int s);
        return (3 * s) >> 1;
    endfunction

    function automatic void push_cmd(input t_cmd cmd, input int a, input int b, input int c,
                                     input int d, input bit [15:0] color);
        t_draw_cmd dc;
        cmds_asked++;
        if (glyph_cmds.size() < MAX_RESULTS) begin
            dc.cmd   = cmd;
            dc.fx    = a[10:0];
            dc.fy    = b[10:0];
            dc.sx    = c[10:0];
            dc.sy    = d[10:0];
            dc.color = color;
            dc.last  = 1'b0;
            glyph_cmds.push_back(dc);
        end
    endfunction

    function automatic void push_px(input int x, input int y, input int c, input int r,
                                    input bit [15:0] color);
        int w, h;
        w = scaled(c + 1) - scaled(c);
        h = scaled(r + 1) - scaled(r);
        push_cmd(CMD_RECT, x + scaled(c), y + scaled(r), (w == 0) ? 1 : w,
                 (h == 0) ? 1 : h, color);
    endfunction

    // expected command list of one glyph, appended to draw_q
    function automatic void rasterize_glyph(input t_glyph g);
        t_font_rec     f;
        bit [0:3][7:0] px;
        int            n, x, y, shape_y, tone_y;
        t_draw_cmd     dc;
        glyph_cmds.delete();
        cmds_asked = 0;
        x = int'(g.x);
        y = int'(g.y);
        shape_y = (y >= 3) ? y - 3 : 0;
        tone_y  = (y >= 6) ? y - 6 : 0;
        f = font_columns(g.ch);
        if (f.known) begin
            for (int col = 0; col < 5; col++)
                for (int row = 0; row < 8; row++)
                    if (f.cols[col][row])
                        push_px(x, y, col, row, g.color);
        end else begin
            push_cmd(CMD_PRINT, x, y + 2, int'(g.ch), 0, g.color);
        end
        if (g.stroke)
            push_cmd(CMD_LINE, x + 2, y + 6, x + 8, y + 3, g.color);
        // mark pixels packed as {col, row} nibbles
        n  = 0;
        px = '0;
        case (g.shape)
            SHAPE_CIRCUMFLEX: begin px = 32'h12_21_31_42; n = 4; end
            SHAPE_BREVE:      begin px = 32'h10_21_31_40; n = 4; end
            SHAPE_HORN:       begin px = 32'h41_50_00_00; n = 2; end
            default:          n = 0;
        endcase
        for (int k = 0; k < n; k++)
            push_px(x, shape_y, int'(px[k][7:4]), int'(px[k][3:0]), g.color);
        n  = 0;
        px = '0;
        case (g.tone)
            TONE_ACUTE: begin px = 32'h41_32_00_00; n = 2; end
            TONE_GRAVE: begin px = 32'h20_31_00_00; n = 2; end
            TONE_HOOK:  begin px = 32'h20_30_31_22; n = 4; end
            TONE_TILDE: begin px = 32'h11_20_31_40; n = 4; end
            default:    n = 0;
        endcase
        for (int k = 0; k < n; k++)
            push_px(x, tone_y, int'(px[k][7:4]), int'(px[k][3:0]), g.color);
        if (g.dot)
            push_px(x, y + 12, 3, 0, g.color);
        if (cmds_asked > MAX_RESULTS)
            capped_cnt++;
        if (glyph_cmds.size() == 0) begin
            empty_cnt++;
        end else begin
            dc = glyph_cmds.pop_back();
            dc.last = 1'b1;
            glyph_cmds.push_back(dc);
        end
        foreach (glyph_cmds[i])
            draw_q.push_back(glyph_cmds[i]);
    endfunction

    function automatic void add_glyph(input bit [7:0] ch, input bit [2:0] tone,
                                      input bit [1:0] shape, input bit dot, input bit stroke,
                                      input bit [9:0] x, input bit [9:0] y,
                                      input bit [15:0] color, input bit drain);
        t_glyph_entry e;
        e.g.ch = ch;
        e.g.tone = tone;
        e.g.shape = shape;
        e.g.dot = dot;
        e.g.stroke = stroke;
        e.g.x = x;
        e.g.y = y;
        e.g.color = color;
        e.drain_before = drain;
        glyph_q.push_back(e);
    endfunction

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
            err_cnt++;
        end
    endtask

    // sender: bursts of items with random gaps, optional wait for an empty pipeline
    t_glyph cur_glyph;
    int     burst_left = 1;
    int     gap_left = 0;

    always @(posedge i_clk) begin : glyph_driver
        bit nxt_valid;
        t_glyph_entry e;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            nxt_valid = i_s_tvalid;
            if (i_s_tvalid && o_s_tready) begin
                rasterize_glyph(cur_glyph);
                glyphs_sent++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (glyph_q.size() > 0 &&
                             !(glyph_q[0].drain_before && draw_q.size() > 0)) begin
                    e = glyph_q.pop_front();
                    cur_glyph = e.g;
                    i_s_tdata <= {5'b0, e.g};
                    nxt_valid = 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
            i_s_tvalid <= nxt_valid;
        end
    end

    // receiver: random ready level that changes now and then, plus rare long holds
    int ready_pct = 100;
    int pct_left = 0;
    int hold_left = 0;
    int next_hold_at = 200;

    always @(posedge i_clk) begin : cmd_receiver
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (pct_left == 0) begin
                case ($urandom_range(0, 4))
                    0, 1: ready_pct = 100;
                    2:    ready_pct = 75;
                    3:    ready_pct = 40;
                    default: ready_pct = 10;
                endcase
                pct_left = $urandom_range(20, 80);
            end else begin
                pct_left--;
            end
            if (hold_left == 0 && cmds_seen >= next_hold_at) begin
                hold_left = LONG_HOLD;
                next_hold_at = next_hold_at + 3500;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(1, 100) <= ready_pct);
            end
        end
    end

    always @(posedge i_clk) begin : cmd_monitor
        t_draw_cmd dc;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            cmds_seen++;
            if (draw_q.size() == 0) begin
                $error("unexpected command: tuser %0d tdata %h", o_m_tuser, o_m_tdata);
                err_cnt++;
            end else begin
                dc = draw_q.pop_front();
                check_field("command", int'(dc.cmd), int'(o_m_tuser));
                check_field("first_x", int'(dc.fx), int'(o_m_tdata[10:0]));
                check_field("first_y", int'(dc.fy), int'(o_m_tdata[21:11]));
                check_field("second_x", int'(dc.sx), int'(o_m_tdata[32:22]));
                check_field("second_y", int'(dc.sy), int'(o_m_tdata[43:33]));
                check_field("out_color", int'(dc.color), int'(o_m_tdata[59:44]));
                check_field("last", int'(dc.last), int'(o_m_tlast));
                case (dc.cmd)
                    CMD_RECT: rect_cnt++;
                    CMD_LINE: line_cnt++;
                    default:  print_cnt++;
                endcase
            end
        end
    end

    int idle_cycles = 0;

    always @(posedge i_clk) begin : watchdog
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin : stimulus
        bit [7:0] ch;
        bit [2:0] tone;
        bit [9:0] x, y;
        // directed: origin corners, every mark, fallback codes, blank glyphs, command cap
        add_glyph("A", TONE_ACUTE, SHAPE_CIRCUMFLEX, 1'b1, 1'b1, 10'd0, 10'd0, 16'h0000, 1'b0);
        add_glyph("B", TONE_HOOK, SHAPE_CIRCUMFLEX, 1'b1, 1'b1, 10'd1023, 10'd1023, 16'hFFFF,
                  1'b0);
        add_glyph(" ", 3'd0, 2'd0, 1'b0, 1'b0, 10'd40, 10'd40, 16'h1234, 1'b0);
        add_glyph(" ", 3'd5, 2'd0, 1'b0, 1'b0, 10'd41, 10'd41, 16'h1234, 1'b0);
        add_glyph(" ", 3'd7, 2'd0, 1'b0, 1'b0, 10'd42, 10'd42, 16'h4321, 1'b0);
        add_glyph("a", 3'd0, 2'd0, 1'b0, 1'b0, 10'd100, 10'd200, 16'h0F0F, 1'b0);
        add_glyph(8'h00, TONE_TILDE, SHAPE_HORN, 1'b1, 1'b0, 10'd7, 10'd8, 16'hF0F0, 1'b0);
        add_glyph(8'hFF, 3'd6, 2'd0, 1'b0, 1'b1, 10'd1023, 10'd0, 16'h8001, 1'b1);
        add_glyph("W", TONE_GRAVE, SHAPE_BREVE, 1'b0, 1'b0, 10'd300, 10'd3, 16'h07E0, 1'b0);
        add_glyph("M", TONE_TILDE, SHAPE_HORN, 1'b0, 1'b0, 10'd301, 10'd5, 16'hF800, 1'b0);
        add_glyph("0", TONE_ACUTE, 2'd0, 1'b0, 1'b0, 10'd302, 10'd6, 16'h001F, 1'b0);
        add_glyph(".", 3'd0, 2'd0, 1'b1, 1'b0, 10'd0, 10'd1023, 16'hFFFF, 1'b0);
        add_glyph(":", 3'd0, 2'd0, 1'b0, 1'b0, 10'd1023, 10'd512, 16'h0001, 1'b0);
        add_glyph("-", 3'd0, 2'd0, 1'b0, 1'b1, 10'd511, 10'd511, 16'h8000, 1'b0);
        add_glyph("/", TONE_TILDE, SHAPE_HORN, 1'b0, 1'b0, 10'd600, 10'd2, 16'hAAAA, 1'b0);
        add_glyph("Z", 3'd0, 2'd0, 1'b0, 1'b0, 10'd650, 10'd700, 16'h5555, 1'b0);
        add_glyph("8", TONE_HOOK, SHAPE_BREVE, 1'b1, 1'b1, 10'd512, 10'd2, 16'hC3C3, 1'b0);
        add_glyph(" ", 3'd0, SHAPE_CIRCUMFLEX, 1'b0, 1'b0, 10'd20, 10'd1, 16'h3C3C, 1'b0);
        add_glyph("I", 3'd0, 2'd0, 1'b1, 1'b0, 10'd1, 10'd0, 16'h00FF, 1'b0);
        add_glyph(" ", 3'd0, 2'd0, 1'b0, 1'b1, 10'd1022, 10'd1022, 16'hFF00, 1'b1);
        add_glyph("D", TONE_GRAVE, 2'd0, 1'b0, 1'b1, 10'd333, 10'd4, 16'h2468, 1'b0);
        add_glyph("z", TONE_HOOK, SHAPE_BREVE, 1'b1, 1'b1, 10'd5, 10'd1020, 16'h1357, 1'b0);

        for (int i = 0; i < RAND_ITEMS; i++) begin
            case ($urandom_range(0, 19))
                0, 1:    ch = 8'(8'h61 + $urandom_range(0, 25));
                2, 3, 4: ch = 8'($urandom_range(0, 255));
                default: ch = FONT_CODES[$urandom_range(0, FONT_CODES.len() - 1)];
            endcase
            tone = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                               : 3'($urandom_range(0, 4));
            case ($urandom_range(0, 7))
                0:       x = ($urandom_range(0, 1) == 0) ? 10'd0 : 10'd1023;
                default: x = 10'($urandom_range(0, 1023));
            endcase
            case ($urandom_range(0, 7))
                0, 1:    y = 10'($urandom_range(0, 7));
                2:       y = 10'(10'd1023 - $urandom_range(0, 3));
                default: y = 10'($urandom_range(0, 1023));
            endcase
            add_glyph(ch, tone, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), x, y, 16'($urandom_range(0, 65535)),
                      $urandom_range(0, 59) == 0);
        end
        glyphs_total = glyph_q.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (glyphs_sent < glyphs_total || draw_q.size() > 0)
            @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);

        if (draw_q.size() != 0) begin
            $error("%0d expected commands never arrived", draw_q.size());
            err_cnt++;
        end
        $display("run covered %0d glyphs and %0d commands: %0d rects, %0d lines, %0d prints",
                 glyphs_sent, cmds_seen, rect_cnt, line_cnt, print_cnt);
        $display("%0d glyphs hit the command cap, %0d glyphs drew nothing",
                 capped_cnt, empty_cnt);
        if (err_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
